### hw/rtl/tsc_pkg.sv
// Shared types and token codes for the token scanner.
// No dependencies; imported by token_scanner.
package tsc_pkg;

    // Token kind codes carried in the result
    localparam logic [2:0] KIND_SEP   = 3'd0;
    localparam logic [2:0] KIND_IDENT = 3'd1;
    localparam logic [2:0] KIND_NUM   = 3'd2;
    localparam logic [2:0] KIND_OP    = 3'd3;
    localparam logic [2:0] KIND_ERR   = 3'd4;
    localparam logic [2:0] KIND_END   = 3'd5;

    // Input transaction: one source byte or the end marker
    typedef struct packed {
        logic [7:0] byte_in;
        logic       at_end;
    } scan_in_t;

    // Output transaction: one kept byte with its classification
    typedef struct packed {
        logic [7:0] char_out;
        logic [2:0] token_kind;
        logic       starts_token;
    } scan_out_t;

endpackage

### hw/rtl/token_scanner.sv
// Streaming lexical scanner: classifies source bytes into token kinds.
// Depends on tsc_pkg for payload types and token kind codes.
//
// Usage: feed one source byte per input transaction, or a transaction with
// at_end set to close the stream. Each byte other than blank, tab, form
// feed, return and vertical tab comes back once, tagged with its token kind
// and a start-of-token flag; the end marker comes back as an end token with
// char_out zero. Whitespace produces no output. The block takes one
// transaction per cycle unless a held result stalls it; a byte is latched
// in an input register, classified combinationally from it and loaded into
// the result register when it advances, and the result is offered from there.
// The two-bit scan mode register is read and updated once per byte.
module token_scanner
    import tsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  scan_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output scan_out_t out_data
);

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_IDENT = 2'd1,
        MODE_NUM   = 2'd2,
        MODE_OPEQ  = 2'd3
    } scan_mode_t;

    // Character class helpers
    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h0C || c == 8'h0D || c == 8'h09 || c == 8'h0B;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic ident_head(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               c == "_" || c == "$";
    endfunction

    function automatic logic num_head(input logic [7:0] c);
        return is_digit(c) || c == "+" || c == "-" || c == ".";
    endfunction

    function automatic logic num_tail(input logic [7:0] c);
        return num_head(c) || c == "_" || c == "e" || c == "E";
    endfunction

    function automatic logic op_extendable(input logic [7:0] c);
        return c == "=" || c == "!" || c == "<" || c == ">";
    endfunction

    function automatic logic op_single(input logic [7:0] c);
        return c == "*" || c == "/" || c == "%" || c == ":" || c == ",";
    endfunction

    scan_in_t   in_reg;
    logic       in_valid_reg;
    scan_out_t  out_reg;
    logic       out_valid_reg;
    scan_mode_t mode_reg;
    scan_mode_t mode_next;

    scan_out_t  result;
    logic       emit;
    logic       advance;
    logic [7:0] c;

    assign c = in_reg.byte_in;

    // Classify the held byte against the current scan mode
    always_comb
    begin
        result.char_out     = c;
        result.token_kind   = KIND_ERR;
        result.starts_token = 1'b1;
        emit                = 1'b1;
        mode_next           = MODE_IDLE;
        if (in_reg.at_end)
        begin
            result.char_out   = 8'd0;
            result.token_kind = KIND_END;
        end
        else if (is_blank(c))
        begin
            emit = 1'b0;
        end
        else if (mode_reg == MODE_IDENT && (ident_head(c) || is_digit(c)))
        begin
            result.token_kind   = KIND_IDENT;
            result.starts_token = 1'b0;
            mode_next           = MODE_IDENT;
        end
        else if (mode_reg == MODE_NUM && num_tail(c))
        begin
            result.token_kind   = KIND_NUM;
            result.starts_token = 1'b0;
            mode_next           = MODE_NUM;
        end
        else if (mode_reg == MODE_OPEQ && c == "=")
        begin
            result.token_kind   = KIND_OP;
            result.starts_token = 1'b0;
        end
        else if (c == ";" || c == 8'h0A)
        begin
            result.token_kind = KIND_SEP;
        end
        else if (ident_head(c))
        begin
            result.token_kind = KIND_IDENT;
            mode_next         = MODE_IDENT;
        end
        else if (num_head(c))
        begin
            result.token_kind = KIND_NUM;
            mode_next         = MODE_NUM;
        end
        else if (op_extendable(c))
        begin
            result.token_kind = KIND_OP;
            mode_next         = MODE_OPEQ;
        end
        else if (op_single(c))
        begin
            result.token_kind = KIND_OP;
        end
    end

    // Advance the held byte when the result slot frees up or nothing is emitted
    assign advance  = in_valid_reg && (!emit || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Hold the input transaction, scan mode and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_IDLE;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                mode_reg <= mode_next;
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_reg <= in_data;
        end
        if (advance && emit)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### tb/token_scanner_tb.sv
// Self-checking testbench for token_scanner: directed and random byte streams.
// Depends on tsc_pkg and the token_scanner RTL; predicts each token in-line.
module token_scanner_tb;
    import tsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 500;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_IDENT, SCAN_NUM, SCAN_OPEQ} scan_mode_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    scan_in_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    scan_out_t out_data;

    scan_mode_t  scan_mode_q = SCAN_IDLE;
    scan_out_t   expected_tokens[$];
    scan_out_t   want_tok;
    bit          idle_on = 1'b0;
    int unsigned n_sent = 0;
    int unsigned n_failures = 0;
    int unsigned quiet_cycles = 0;

    // Character pools for well-formed tokens
    string ident_head_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_$";
    string ident_tail_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_$0123456789";
    string num_head_chars   = "0123456789+-.";
    string num_tail_chars   = "0123456789+-._eE";
    string op_chars         = "=!<>*/%:,";
    string sep_chars        = ";\n";
    logic [7:0] blank_codes [5] = '{8'h20, 8'h09, 8'h0C, 8'h0D, 8'h0B};

    token_scanner u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Character classes
    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit ident_head(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == "$";
    endfunction

    function automatic bit num_head(input logic [7:0] c);
        return is_digit(c) || c == "+" || c == "-" || c == ".";
    endfunction

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // Advance the scan mode and queue the token byte this transaction yields
    task automatic predict_token(input scan_in_t t);
        logic [7:0] c;
        scan_out_t  r;
        c = t.byte_in;
        r.char_out = c;
        r.starts_token = 1'b1;
        if (t.at_end)
        begin
            scan_mode_q = SCAN_IDLE;
            r.char_out = '0;
            r.token_kind = KIND_END;
            expected_tokens.push_back(r);
        end
        else if (c == 8'h20 || c == 8'h0C || c == 8'h0D || c == 8'h09 || c == 8'h0B)
        begin
            // whitespace closes any open token and yields nothing
            scan_mode_q = SCAN_IDLE;
        end
        else
        begin
            if (scan_mode_q == SCAN_IDENT && (ident_head(c) || is_digit(c)))
            begin
                r.token_kind = KIND_IDENT;
                r.starts_token = 1'b0;
            end
            else if (scan_mode_q == SCAN_NUM && (num_head(c) || c == "_" || c == "e"
                                                 || c == "E"))
            begin
                r.token_kind = KIND_NUM;
                r.starts_token = 1'b0;
            end
            else if (scan_mode_q == SCAN_OPEQ && c == "=")
            begin
                r.token_kind = KIND_OP;
                r.starts_token = 1'b0;
                scan_mode_q = SCAN_IDLE;
            end
            else if (c == ";" || c == 8'h0A)
            begin
                r.token_kind = KIND_SEP;
                scan_mode_q = SCAN_IDLE;
            end
            else if (ident_head(c))
            begin
                r.token_kind = KIND_IDENT;
                scan_mode_q = SCAN_IDENT;
            end
            else if (num_head(c))
            begin
                r.token_kind = KIND_NUM;
                scan_mode_q = SCAN_NUM;
            end
            else if (c == "=" || c == "!" || c == "<" || c == ">")
            begin
                r.token_kind = KIND_OP;
                scan_mode_q = SCAN_OPEQ;
            end
            else if (c == "*" || c == "/" || c == "%" || c == ":" || c == ",")
            begin
                r.token_kind = KIND_OP;
                scan_mode_q = SCAN_IDLE;
            end
            else
            begin
                r.token_kind = KIND_ERR;
                scan_mode_q = SCAN_IDLE;
            end
            expected_tokens.push_back(r);
        end
    endtask

    // Send one transaction, with an optional gap before it
    task automatic send_item(input logic [7:0] b, input logic e);
        scan_in_t t;
        t.byte_in = b;
        t.at_end = e;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= t;
        do @(posedge clk); while (!in_ready);
        predict_token(t);
        n_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    // Hold the input until every expected token is back, then let the pipe empty
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic report_failure(input string what, input scan_out_t exp_tok,
                                  input scan_out_t got_tok);
        n_failures++;
        if (n_failures <= 10)
            $display("%0t: %s: expected char %h kind %0d start %b, got char %h kind %0d start %b",
                     $realtime, what, exp_tok.char_out, exp_tok.token_kind,
                     exp_tok.starts_token, got_tok.char_out, got_tok.token_kind,
                     got_tok.starts_token);
    endtask

    // One well-formed token with random content, or noise, a run of blanks or an end marker
    task automatic send_random_token();
        int unsigned choice;
        choice = $urandom_range(0, 19);
        if (choice < 5)
        begin
            send_item(pick(ident_head_chars), 1'b0);
            repeat ($urandom_range(0, 6)) send_item(pick(ident_tail_chars), 1'b0);
        end
        else if (choice < 9)
        begin
            send_item(pick(num_head_chars), 1'b0);
            repeat ($urandom_range(0, 6)) send_item(pick(num_tail_chars), 1'b0);
        end
        else if (choice < 13)
        begin
            send_item(pick(op_chars), 1'b0);
            if ($urandom_range(0, 1) == 1)
                send_item("=", 1'b0);
        end
        else if (choice < 15)
        begin
            send_item(pick(sep_chars), 1'b0);
        end
        else if (choice < 18)
        begin
            send_item(8'($urandom_range(0, 255)), 1'b0);
        end
        else if (choice < 19)
        begin
            repeat ($urandom_range(1, 3)) send_item(blank_codes[$urandom_range(0, 4)], 1'b0);
        end
        else
        begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end
        // often split tokens with whitespace, otherwise let them abut
        if ($urandom_range(0, 9) < 4)
            send_item(blank_codes[$urandom_range(0, 4)], 1'b0);
    endtask

    // Field extremes, every class, operator extension, blanks and end markers
    task automatic test_directed();
        idle_on = 1'b1;
        send_text("$x9");
        send_item(8'h09, 1'b0);
        send_text("+.1E_;<==>!");
        send_item(8'h0A, 1'b0);
        send_text("%:,*/");
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h0C, 1'b0);
        send_item(8'h0D, 1'b0);
        send_item(8'h0B, 1'b0);
        send_text("9a");
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b1);
        send_text("e");
    endtask

    // Token streams in stretches with and without idling, drained once after 60 tokens
    task automatic test_token_stream();
        int unsigned first;
        int unsigned tokens;
        first = n_sent;
        tokens = 0;
        while (n_sent - first < 500)
        begin
            if (tokens % 40 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            send_random_token();
            tokens++;
            if (tokens == 60)
                wait_drain();
        end
    endtask

    // Uniform byte noise with scattered end markers
    task automatic test_byte_noise();
        idle_on = 1'b1;
        repeat (150)
            send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0));
    endtask

    // Closing stretch at full rate on both sides
    task automatic test_unstalled_stream();
        int unsigned first;
        idle_on = 1'b0;
        first = n_sent;
        while (n_sent - first < 150)
            send_random_token();
    endtask

    // Drive result ready with random stall bursts
    initial
    begin : result_pacing
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest expected token
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_tokens.size() == 0)
            begin
                report_failure("unexpected result", '0, out_data);
            end
            else
            begin
                want_tok = expected_tokens.pop_front();
                if (out_data.char_out !== want_tok.char_out ||
                    out_data.token_kind !== want_tok.token_kind ||
                    out_data.starts_token !== want_tok.starts_token)
                    report_failure("token mismatch", want_tok, out_data);
            end
        end
    end

    // End the run when nothing moves for too long
    initial
    begin : watchdog
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("token_scanner test failed");
        $finish;
    end

    initial
    begin : run
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_token_stream();
        test_byte_noise();
        test_unstalled_stream();
        wait_drain();
        if (n_failures == 0)
            $display("token_scanner test passed");
        else
            $display("token_scanner test failed");
        $finish;
    end

endmodule
